FILE: sv/dpms_pkg.sv
// Shared types and constants of the dielectron pair mass selector.
`timescale 1ns / 1ps
`default_nettype none
package dpms_pkg;

	localparam int COEF_W      = 24;
	localparam int BOUND_W     = 36;
	localparam int CFG_W       = 36;
	localparam int CFG_IDX_W   = 3;
	localparam int COEF_FRAC   = 16;
	localparam int FLAG_PROMPT = 1;
	localparam int FLAG_HARD   = 9;
	localparam int NUM_SEL     = 3;
	localparam int SQRT_STEPS  = 18;
	localparam int MASS_W      = 20;
	localparam int KIND_W      = 2;
	localparam int STEP_W      = 5;

	localparam logic signed [15:0] ELECTRON_CODE = 16'sd11;
	localparam logic [7:0]         FINAL_STATE   = 8'd1;

	localparam logic [BOUND_W-1:0] PT_MIN_RST     = 36'd160000;
	localparam logic [COEF_W-1:0]  ETA_MAX_RST    = 24'd2398960;
	localparam logic [COEF_W-1:0]  CRACK_LOW_RST  = 24'd262485;
	localparam logic [COEF_W-1:0]  CRACK_HIGH_RST = 24'd343468;
	localparam logic [BOUND_W-1:0] MASS_LOW_RST   = 36'd921600;
	localparam logic [BOUND_W-1:0] MASS_HIGH_RST  = 36'd3686400;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PT_MIN     = 3'd0,
		CFG_ETA_MAX    = 3'd1,
		CFG_CRACK_LOW  = 3'd2,
		CFG_CRACK_HIGH = 3'd3,
		CFG_MASS_LOW   = 3'd4,
		CFG_MASS_HIGH  = 3'd5
	} cfg_idx_t;

	// cut coefficient / selection index
	localparam logic [1:0] IDX_ETA   = 2'd0;
	localparam logic [1:0] IDX_CLOW  = 2'd1;
	localparam logic [1:0] IDX_LAST  = 2'd2;

	typedef enum logic [3:0] {
		MS_NONE, MS_XX, MS_YY, MS_ZZ, MS_CLO, MS_CHI, MS_EE, MS_SX, MS_SY, MS_SZ
	} mul_sel_t;

	typedef enum logic [3:0] {
		ACC_NONE, ACC_PT2_SET, ACC_PT2_ADD, ACC_PZ2_SET, ACC_CUT_LO, ACC_CUT_HI,
		ACC_E2_SET, ACC_P2_SET, ACC_P2_ADD
	} acc_op_t;

	typedef struct packed {
		logic     load_item;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic [1:0] idx;
		logic     cut_cmp;
		logic     keep;
		logic     pair_load;
		logic     win_diff;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     res_push;
		logic     flush;
		logic     clr_counts;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic sel0_full;
		logic seli_full;
		logic in_window;
		logic out_free;
		logic pend_valid;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: sv/dpms_ctrl.sv
// Sequencer of the dielectron pair mass selector.
`timescale 1ns / 1ps
`default_nettype none
module dpms_ctrl import dpms_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire logic   in_has,
	input  wire logic   in_last,
	input  dp_status_t  status,
	output dp_cmd_t     cmd,
	output logic        in_stall
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_XX, ST_YY, ST_ZZ, ST_PZ, ST_CLO, ST_CHI, ST_CACC, ST_CMP, ST_KEEP,
		ST_END, ST_PSEL, ST_PAIR, ST_EE, ST_SX, ST_SY, ST_SZ, ST_PACC, ST_DIFF, ST_CHK,
		ST_SQI, ST_SQ, ST_RES, ST_NEXT, ST_FLUSH, ST_CLR
	} state_t;

	state_t            state_q;
	logic [1:0]        k_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_has) state_q <= ST_XX;
						else if (in_last) state_q <= ST_END;
					end
				end
				ST_XX: state_q <= ST_YY;
				ST_YY: state_q <= ST_ZZ;
				ST_ZZ: state_q <= ST_PZ;
				ST_PZ: begin
					k_q     <= IDX_ETA;
					state_q <= ST_CLO;
				end
				ST_CLO:  state_q <= ST_CHI;
				ST_CHI:  state_q <= ST_CACC;
				ST_CACC: state_q <= ST_CMP;
				ST_CMP: begin
					if (k_q == IDX_LAST) begin
						k_q     <= '0;
						state_q <= ST_KEEP;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_CLO;
					end
				end
				ST_KEEP: state_q <= status.last ? ST_END : ST_IDLE;
				ST_END: begin
					k_q     <= '0;
					state_q <= status.sel0_full ? ST_PSEL : ST_CLR;
				end
				ST_PSEL: state_q <= status.seli_full ? ST_PAIR : ST_NEXT;
				ST_PAIR: state_q <= ST_EE;
				ST_EE:   state_q <= ST_SX;
				ST_SX:   state_q <= ST_SY;
				ST_SY:   state_q <= ST_SZ;
				ST_SZ:   state_q <= ST_PACC;
				ST_PACC: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_CHK;
				ST_CHK:  state_q <= status.in_window ? ST_SQI : ST_NEXT;
				ST_SQI: begin
					step_q  <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (step_q == STEP_W'(SQRT_STEPS - 1)) state_q <= ST_RES;
					else step_q <= step_q + STEP_W'(1);
				end
				ST_RES: begin
					if (!status.pend_valid || status.out_free) state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (k_q == IDX_LAST) begin
						state_q <= ST_FLUSH;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_PSEL;
					end
				end
				ST_FLUSH: begin
					if (!status.pend_valid || status.out_free) state_q <= ST_CLR;
				end
				ST_CLR:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MS_NONE;
		cmd.acc_op    = ACC_NONE;
		cmd.idx       = k_q;
		cmd.load_item = accept;
		unique case (state_q)
			ST_XX:   cmd.mul_sel = MS_XX;
			ST_YY: begin
				cmd.mul_sel = MS_YY;
				cmd.acc_op  = ACC_PT2_SET;
			end
			ST_ZZ: begin
				cmd.mul_sel = MS_ZZ;
				cmd.acc_op  = ACC_PT2_ADD;
			end
			ST_PZ:   cmd.acc_op = ACC_PZ2_SET;
			ST_CLO:  cmd.mul_sel = MS_CLO;
			ST_CHI: begin
				cmd.mul_sel = MS_CHI;
				cmd.acc_op  = ACC_CUT_LO;
			end
			ST_CACC: cmd.acc_op = ACC_CUT_HI;
			ST_CMP:  cmd.cut_cmp = 1'b1;
			ST_KEEP: cmd.keep = 1'b1;
			ST_PAIR: cmd.pair_load = 1'b1;
			ST_EE:   cmd.mul_sel = MS_EE;
			ST_SX: begin
				cmd.mul_sel = MS_SX;
				cmd.acc_op  = ACC_E2_SET;
			end
			ST_SY: begin
				cmd.mul_sel = MS_SY;
				cmd.acc_op  = ACC_P2_SET;
			end
			ST_SZ: begin
				cmd.mul_sel = MS_SZ;
				cmd.acc_op  = ACC_P2_ADD;
			end
			ST_PACC:  cmd.acc_op = ACC_P2_ADD;
			ST_DIFF:  cmd.win_diff = 1'b1;
			ST_SQI:   cmd.sqrt_init = 1'b1;
			ST_SQ:    cmd.sqrt_step = 1'b1;
			ST_RES:   cmd.res_push = !status.pend_valid || status.out_free;
			ST_FLUSH: cmd.flush = status.pend_valid && status.out_free;
			ST_CLR:   cmd.clr_counts = 1'b1;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/dpms_datapath.sv
// Datapath: item latch, shared multiplier, cuts, pair store, mass window and square root.
`timescale 1ns / 1ps
`default_nettype none
module dpms_datapath import dpms_pkg::*; #(
	parameter int MOM_WIDTH = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  dp_cmd_t                          cmd,
	output dp_status_t                       status,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_data,
	input  wire logic signed [MOM_WIDTH-1:0] mom_x,
	input  wire logic signed [MOM_WIDTH-1:0] mom_y,
	input  wire logic signed [MOM_WIDTH-1:0] mom_z,
	input  wire logic [MOM_WIDTH-1:0]        energy,
	input  wire logic [7:0]                  gen_status,
	input  wire logic [14:0]                 status_flags,
	input  wire logic signed [15:0]          species_code,
	input  wire logic signed [1:0]           weight_sign,
	input  wire logic                        last_of_event,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [KIND_W-1:0]                pair_kind,
	output logic [MASS_W-1:0]                pair_mass,
	output logic signed [1:0]                event_weight,
	output logic                             last_result
);

	localparam int MW     = MOM_WIDTH;
	localparam int SW     = MW + 1;
	localparam int MUL_W  = (SW > COEF_W) ? SW : COEF_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int PT2_W  = 2 * MW + 1;
	localparam int HALF   = MW + 1;
	localparam int CW     = 2 * MW + COEF_W + 1;
	localparam int SQW    = 2 * SW;
	localparam int P2_W   = SQW + 2;
	localparam int DIFF_W = P2_W + 1;
	localparam int DW2    = (P2_W > BOUND_W) ? P2_W : BOUND_W;
	localparam int RW     = BOUND_W + 2;

	// configuration
	logic [BOUND_W-1:0] pt_min_q, mass_low_q, mass_high_q;
	logic [COEF_W-1:0]  eta_max_q, crack_low_q, crack_high_q;

	// latched item
	logic                 last_q;
	logic signed [MW-1:0] px_q, py_q, pz_q;
	logic [MW-1:0]        e_q;
	logic [7:0]           gstat_q;
	logic [14:0]          flags_q;
	logic signed [15:0]   code_q;
	logic signed [1:0]    sticky_q;

	// arithmetic state
	logic [PROD_W-1:0] prod_q;
	logic [PT2_W-1:0]  pt2_q;
	logic [2*MW-1:0]   pz2_q;
	logic [CW-1:0]     acc_q;
	logic [2:0]        cut_q;
	logic [SW-1:0]     esum_q, sxm_q, sym_q, szm_q;
	logic [SQW-1:0]    e2_q;
	logic [P2_W-1:0]   p2_q;
	logic [DIFF_W-1:0] diff_q;
	logic [RW-1:0]     sq_v_q, sq_r_q, sq_b_q;

	// pair store, two slots per selection
	logic signed [MW-1:0] mx_q [NUM_SEL][2];
	logic signed [MW-1:0] my_q [NUM_SEL][2];
	logic signed [MW-1:0] mz_q [NUM_SEL][2];
	logic [MW-1:0]        me_q [NUM_SEL][2];
	logic [1:0]           count_q [NUM_SEL];

	// pending result and output register
	logic              pend_valid_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [MASS_W-1:0] pend_mass_q;
	logic signed [1:0] pend_w_q;
	logic              out_valid_q;

	logic [MW-1:0]       ax, ay, az;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [COEF_W-1:0]   coef_k;
	logic [CW-1:0]       lhs;
	logic                pt_ok, kin, ele, prompt_fs, hard;
	logic [NUM_SEL-1:0]  take;
	logic signed [SW-1:0] sum_x, sum_y, sum_z;
	logic [SW-1:0]       e_sum;
	logic [DW2-1:0]      m2_ext;
	logic                in_window;
	logic [RW-1:0]       sq_t;
	logic                out_free;

	assign ax = px_q[MW-1] ? MW'(-px_q) : MW'(px_q);
	assign ay = py_q[MW-1] ? MW'(-py_q) : MW'(py_q);
	assign az = pz_q[MW-1] ? MW'(-pz_q) : MW'(pz_q);

	always_comb begin
		case (cmd.idx)
			IDX_ETA:  coef_k = eta_max_q;
			IDX_CLOW: coef_k = crack_low_q;
			default:  coef_k = crack_high_q;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MS_XX: begin
				mul_a = MUL_W'(ax);
				mul_b = MUL_W'(ax);
			end
			MS_YY: begin
				mul_a = MUL_W'(ay);
				mul_b = MUL_W'(ay);
			end
			MS_ZZ: begin
				mul_a = MUL_W'(az);
				mul_b = MUL_W'(az);
			end
			MS_CLO: begin
				mul_a = MUL_W'(coef_k);
				mul_b = MUL_W'(pt2_q[HALF-1:0]);
			end
			MS_CHI: begin
				mul_a = MUL_W'(coef_k);
				mul_b = MUL_W'(pt2_q[PT2_W-1:HALF]);
			end
			MS_EE: begin
				mul_a = MUL_W'(esum_q);
				mul_b = MUL_W'(esum_q);
			end
			MS_SX: begin
				mul_a = MUL_W'(sxm_q);
				mul_b = MUL_W'(sxm_q);
			end
			MS_SY: begin
				mul_a = MUL_W'(sym_q);
				mul_b = MUL_W'(sym_q);
			end
			MS_SZ: begin
				mul_a = MUL_W'(szm_q);
				mul_b = MUL_W'(szm_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// pz^2 in Q.16 against coef * pt^2
	assign lhs       = CW'({pz2_q, {COEF_FRAC{1'b0}}});
	assign pt_ok     = CW'(pt2_q) > CW'(pt_min_q);
	assign kin       = pt_ok && cut_q[0] && !(cut_q[1] && cut_q[2]);
	assign ele       = (code_q == ELECTRON_CODE) || (code_q == -ELECTRON_CODE);
	assign prompt_fs = ele && (gstat_q == FINAL_STATE) && flags_q[FLAG_PROMPT];
	assign hard      = ele && flags_q[FLAG_HARD];
	assign take      = {hard && kin, prompt_fs && kin, prompt_fs};

	assign sum_x = SW'(mx_q[cmd.idx][0]) + SW'(mx_q[cmd.idx][1]);
	assign sum_y = SW'(my_q[cmd.idx][0]) + SW'(my_q[cmd.idx][1]);
	assign sum_z = SW'(mz_q[cmd.idx][0]) + SW'(mz_q[cmd.idx][1]);
	assign e_sum = SW'(me_q[cmd.idx][0]) + SW'(me_q[cmd.idx][1]);

	// negative squared mass never passes
	assign m2_ext    = DW2'(diff_q[P2_W-1:0]);
	assign in_window = !diff_q[DIFF_W-1] && (m2_ext >= DW2'(mass_low_q))
		&& (m2_ext <= DW2'(mass_high_q));

	assign sq_t     = sq_r_q + sq_b_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q     <= PT_MIN_RST;
			eta_max_q    <= ETA_MAX_RST;
			crack_low_q  <= CRACK_LOW_RST;
			crack_high_q <= CRACK_HIGH_RST;
			mass_low_q   <= MASS_LOW_RST;
			mass_high_q  <= MASS_HIGH_RST;
			sticky_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int s = 0; s < NUM_SEL; s++) count_q[s] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PT_MIN:     pt_min_q     <= cfg_data[BOUND_W-1:0];
					CFG_ETA_MAX:    eta_max_q    <= cfg_data[COEF_W-1:0];
					CFG_CRACK_LOW:  crack_low_q  <= cfg_data[COEF_W-1:0];
					CFG_CRACK_HIGH: crack_high_q <= cfg_data[COEF_W-1:0];
					CFG_MASS_LOW:   mass_low_q   <= cfg_data[BOUND_W-1:0];
					CFG_MASS_HIGH:  mass_high_q  <= cfg_data[BOUND_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				if (weight_sign[1]) sticky_q <= -2'sd1;
				else if (weight_sign[0]) sticky_q <= 2'sd1;
			end
			if (cmd.keep) begin
				for (int s = 0; s < NUM_SEL; s++) begin
					if (take[s] && count_q[s] != 2'd2) count_q[s] <= count_q[s] + 2'd1;
				end
			end
			if (cmd.clr_counts) begin
				for (int s = 0; s < NUM_SEL; s++) count_q[s] <= '0;
			end
			if (cmd.res_push) pend_valid_q <= 1'b1;
			else if (cmd.flush) pend_valid_q <= 1'b0;
			if ((cmd.res_push && pend_valid_q) || cmd.flush) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			last_q  <= last_of_event;
			px_q    <= mom_x;
			py_q    <= mom_y;
			pz_q    <= mom_z;
			e_q     <= energy;
			gstat_q <= gen_status;
			flags_q <= status_flags;
			code_q  <= species_code;
		end
		prod_q <= mul_p;
		case (cmd.acc_op)
			ACC_PT2_SET: pt2_q <= PT2_W'(prod_q);
			ACC_PT2_ADD: pt2_q <= pt2_q + PT2_W'(prod_q);
			ACC_PZ2_SET: pz2_q <= (2*MW)'(prod_q);
			ACC_CUT_LO:  acc_q <= CW'(prod_q);
			ACC_CUT_HI:  acc_q <= acc_q + (CW'(prod_q) << HALF);
			ACC_E2_SET:  e2_q  <= SQW'(prod_q);
			ACC_P2_SET:  p2_q  <= P2_W'(prod_q);
			ACC_P2_ADD:  p2_q  <= p2_q + P2_W'(prod_q);
			default: ;
		endcase
		if (cmd.cut_cmp) begin
			case (cmd.idx)
				IDX_ETA:  cut_q[0] <= lhs < acc_q;
				IDX_CLOW: cut_q[1] <= lhs > acc_q;
				default:  cut_q[2] <= lhs < acc_q;
			endcase
		end
		if (cmd.keep) begin
			for (int s = 0; s < NUM_SEL; s++) begin
				if (take[s] && count_q[s] != 2'd2) begin
					mx_q[s][count_q[s][0]] <= px_q;
					my_q[s][count_q[s][0]] <= py_q;
					mz_q[s][count_q[s][0]] <= pz_q;
					me_q[s][count_q[s][0]] <= e_q;
				end
			end
		end
		if (cmd.pair_load) begin
			esum_q <= e_sum;
			sxm_q  <= sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
			sym_q  <= sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
			szm_q  <= sum_z[SW-1] ? SW'(-sum_z) : SW'(sum_z);
		end
		if (cmd.win_diff) diff_q <= DIFF_W'(e2_q) - DIFF_W'(p2_q);
		if (cmd.sqrt_init) begin
			sq_v_q <= RW'(m2_ext[BOUND_W-1:0]);
			sq_r_q <= '0;
			sq_b_q <= RW'(1) << (2 * (SQRT_STEPS - 1));
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q <= sq_v_q - sq_t;
				sq_r_q <= (sq_r_q >> 1) + sq_b_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_b_q <= sq_b_q >> 2;
		end
		if (cmd.res_push) begin
			pend_kind_q <= cmd.idx;
			pend_mass_q <= MASS_W'(sq_r_q);
			pend_w_q    <= sticky_q;
		end
		if ((cmd.res_push && pend_valid_q) || cmd.flush) begin
			pair_kind    <= pend_kind_q;
			pair_mass    <= pend_mass_q;
			event_weight <= pend_w_q;
			last_result  <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;

	assign status.last         = last_q;
	assign status.sel0_full    = (count_q[0] == 2'd2);
	assign status.seli_full    = (count_q[cmd.idx] == 2'd2);
	assign status.in_window    = in_window;
	assign status.out_free     = out_free;
	assign status.pend_valid   = pend_valid_q;

endmodule
`default_nettype wire

FILE: sv/dielectron_pair_mass_selector_core.sv
// Top level of the dielectron pair mass selector.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one generator particle per input beat and applies three electron
// selections: prompt final state, prompt final state with pt/eta/crack cuts,
// and hard process with the same cuts. Each selection keeps its first two
// electrons. On the last beat of an event, if the prompt selection holds two,
// each full selection whose squared pair mass lies in the inclusive window
// emits one output beat (kind 0, 1, 2 in order) with floor(sqrt) mass and the
// sticky weight sign; last_result marks the event's final beat. One item at
// a time: one shared multiplier does the three squares and the three 24-bit
// coefficient products (in two halves each) of a particle; the square root,
// an 18-step loop, runs only for a full selection whose pair passes the
// window, and the output side may stall a waiting beat.
// A result is held one place back so the last flag is known; the output
// register lets a waiting beat sit while the sequencer carries on.
module dielectron_pair_mass_selector_core import dpms_pkg::*; #(
	parameter int MOM_WIDTH = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        has_particle,
	input  wire logic signed [MOM_WIDTH-1:0] mom_x,
	input  wire logic signed [MOM_WIDTH-1:0] mom_y,
	input  wire logic signed [MOM_WIDTH-1:0] mom_z,
	input  wire logic [MOM_WIDTH-1:0]        energy,
	input  wire logic [7:0]                  gen_status,
	input  wire logic [14:0]                 status_flags,
	input  wire logic signed [15:0]          species_code,
	input  wire logic signed [1:0]           weight_sign,
	input  wire logic                        last_of_event,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [KIND_W-1:0]                pair_kind,
	output logic [MASS_W-1:0]                pair_mass,
	output logic signed [1:0]                event_weight,
	output logic                             last_result,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: one state per multiplier or compare step
	dpms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_has   (has_particle),
		.in_last  (last_of_event),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// datapath: config, pair store, multiplier, window, square root, output beat
	dpms_datapath #(
		.MOM_WIDTH (MOM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mom_x        (mom_x),
		.mom_y        (mom_y),
		.mom_z        (mom_z),
		.energy       (energy),
		.gen_status   (gen_status),
		.status_flags (status_flags),
		.species_code (species_code),
		.weight_sign  (weight_sign),
		.last_of_event(last_of_event),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pair_kind    (pair_kind),
		.pair_mass    (pair_mass),
		.event_weight (event_weight),
		.last_result  (last_result)
	);

endmodule
`default_nettype wire

FILE: sv/dpms_checker.sv
// Port-level checker of the dielectron pair mass selector and its bind.
`timescale 1ns / 1ps
`default_nettype none
module dpms_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        has_particle,
	input wire logic        last_of_event,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  pair_kind,
	input wire logic [19:0] pair_mass,
	input wire logic [1:0]  event_weight,
	input wire logic        last_result
);

	// a stalled output beat stays and holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
		&& $stable({pair_kind, pair_mass, event_weight, last_result}))
		else $error("stalled output beat changed");

	// a weight-only beat leaves the block ready
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !has_particle && !last_of_event |=> !in_stall)
		else $error("not ready after weight-only beat");

	// event end always starts work
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_of_event |=> in_stall)
		else $error("event end did not start work");

	// a particle always goes through the cut sequence
	a_part_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && has_particle |=> in_stall)
		else $error("particle did not start work");

endmodule

bind dielectron_pair_mass_selector_core dpms_checker u_chk (.*);
`default_nettype wire
